// ===== sv/binary_min_heap_priority_queue_top_defines.svh =====
// assertion macros for the heap queue checker
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH

// clocked check, masked while reset is asserted
`define BMHPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define BMHPQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bmhpq_pkg.sv =====
// shared types and constants of the binary min-heap priority queue
`default_nettype none
package bmhpq_pkg;

	localparam int KEY_W        = 8;
	localparam int TAG_W        = 16;
	localparam int FILL_W       = 5;
	localparam int CAPACITY_DEF = 16;

	typedef enum logic {
		KIND_INSERT  = 1'b0,
		KIND_EXTRACT = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		STAT_INSERTED  = 2'd0,
		STAT_EXTRACTED = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		kind_t            kind;
		logic [TAG_W-1:0] tag_in;
		logic [KEY_W-1:0] key_in;
	} in_item_t;

	typedef struct packed {
		status_t           status;
		logic [TAG_W-1:0]  tag_out;
		logic [KEY_W-1:0]  key_out;
		logic [FILL_W-1:0] fill;
	} out_item_t;

	// one heap slot
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_CHK,
		S_UP_CMP,
		S_EX_RD,
		S_EX_LD,
		S_DN_CHK,
		S_DN_CMP,
		S_DONE
	} state_t;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		DP_NOP,
		DP_START_INS,
		DP_START_EXT,
		DP_REFUSE_FULL,
		DP_REFUSE_EMPTY,
		DP_UP_READ,
		DP_UP_MOVE,
		DP_PLACE,
		DP_EX_READ,
		DP_EX_LOAD,
		DP_DN_READ,
		DP_DN_MOVE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic hole_root;
		logic up_climb;
		logic dn_leaf;
		logic dn_sink;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== sv/bmhpq_ctrl.sv =====
// sequencing state machine of the heap queue
`default_nettype none
module bmhpq_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire bmhpq_pkg::kind_t    in_kind,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire bmhpq_pkg::dp_stat_t stat,
	output bmhpq_pkg::dp_cmd_t       cmd
);
	import bmhpq_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// output beat valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// next state and datapath commands
	always_comb begin
		state_nxt    = state_q;
		cmd.op       = DP_NOP;
		cmd.load_out = 1'b0;
		in_ready     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_kind == KIND_INSERT) begin
						if (stat.full) begin
							cmd.op    = DP_REFUSE_FULL;
							state_nxt = S_DONE;
						end else begin
							cmd.op    = DP_START_INS;
							state_nxt = S_UP_CHK;
						end
					end else begin
						if (stat.empty) begin
							cmd.op    = DP_REFUSE_EMPTY;
							state_nxt = S_DONE;
						end else begin
							cmd.op    = DP_START_EXT;
							state_nxt = S_EX_RD;
						end
					end
				end
			end
			S_UP_CHK: begin
				if (stat.hole_root) begin
					cmd.op    = DP_PLACE;
					state_nxt = S_DONE;
				end else begin
					cmd.op    = DP_UP_READ;
					state_nxt = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (stat.up_climb) begin
					cmd.op    = DP_UP_MOVE;
					state_nxt = S_UP_CHK;
				end else begin
					cmd.op    = DP_PLACE;
					state_nxt = S_DONE;
				end
			end
			S_EX_RD: begin
				cmd.op    = DP_EX_READ;
				state_nxt = S_EX_LD;
			end
			S_EX_LD: begin
				cmd.op    = DP_EX_LOAD;
				state_nxt = S_DN_CHK;
			end
			S_DN_CHK: begin
				if (stat.dn_leaf) begin
					cmd.op    = DP_PLACE;
					state_nxt = S_DONE;
				end else begin
					cmd.op    = DP_DN_READ;
					state_nxt = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				if (stat.dn_sink) begin
					cmd.op    = DP_DN_MOVE;
					state_nxt = S_DN_CHK;
				end else begin
					cmd.op    = DP_PLACE;
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				// wait until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/bmhpq_dp.sv =====
// heap storage, sift registers and result register of the heap queue
`default_nettype none
module bmhpq_dp #(
	parameter int CAPACITY = bmhpq_pkg::CAPACITY_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bmhpq_pkg::in_item_t in_data,
	input  wire bmhpq_pkg::dp_cmd_t  cmd,
	output bmhpq_pkg::dp_stat_t      stat,
	output bmhpq_pkg::out_item_t     out_data
);
	import bmhpq_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = IW + 1;

	entry_t          mem [CAPACITY];
	entry_t          rd0_q;
	entry_t          rd1_q;
	entry_t          moving_q;
	entry_t          res_entry_q;
	status_t         res_status_q;
	out_item_t       out_q;
	logic [IW-1:0]   hole_q;
	logic [CW-1:0]   count_q;

	logic [IW-1:0]   hole_m1;
	logic [IW-1:0]   parent;
	logic [XW-1:0]   left_x;
	logic [XW-1:0]   right_x;
	logic [XW-1:0]   count_x;
	logic            pick_r;
	entry_t          child;
	logic [IW-1:0]   child_idx;

	logic [IW-1:0]   rd_addr0;
	logic [IW-1:0]   rd_addr1;
	logic            wr_en;
	logic [IW-1:0]   wr_addr;
	entry_t          wr_data;

	// neighbor indexes of the hole
	assign hole_m1 = hole_q - IW'(1);
	assign parent  = hole_m1 >> 1;
	assign left_x  = {hole_q, 1'b1};
	assign right_x = left_x + XW'(1);
	assign count_x = XW'(count_q);

	// smaller child, right only when strictly smaller
	assign pick_r    = (right_x < count_x) && (rd1_q.key < rd0_q.key);
	assign child     = pick_r ? rd1_q : rd0_q;
	assign child_idx = pick_r ? right_x[IW-1:0] : left_x[IW-1:0];

	// status to the controller
	assign stat.full      = (count_q == CW'(CAPACITY));
	assign stat.empty     = (count_q == '0);
	assign stat.hole_root = (hole_q == '0);
	assign stat.up_climb  = (moving_q.key < rd0_q.key);
	assign stat.dn_leaf   = (left_x >= count_x);
	assign stat.dn_sink   = (child.key < moving_q.key);

	// memory address and write selection
	always_comb begin
		rd_addr0 = '0;
		rd_addr1 = '0;
		wr_en    = 1'b0;
		wr_addr  = hole_q;
		wr_data  = moving_q;
		unique case (cmd.op)
			DP_UP_READ: begin
				rd_addr0 = parent;
			end
			DP_EX_READ: begin
				rd_addr0 = '0;
				rd_addr1 = count_q[IW-1:0];
			end
			DP_DN_READ: begin
				rd_addr0 = left_x[IW-1:0];
				rd_addr1 = right_x[IW-1:0];
			end
			DP_PLACE: begin
				wr_en   = 1'b1;
				wr_data = moving_q;
			end
			DP_UP_MOVE: begin
				wr_en   = 1'b1;
				wr_data = rd0_q;
			end
			DP_DN_MOVE: begin
				wr_en   = 1'b1;
				wr_data = child;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// heap store, one write and two registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd0_q <= mem[rd_addr0];
		rd1_q <= mem[rd_addr1];
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.op == DP_START_INS) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.op == DP_START_EXT) begin
			count_q <= count_q - CW'(1);
		end
	end

	// sift and result registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_START_INS: begin
				moving_q     <= '{key: in_data.key_in, tag: in_data.tag_in};
				hole_q       <= count_q[IW-1:0];
				res_status_q <= STAT_INSERTED;
				res_entry_q  <= '0;
			end
			DP_START_EXT: begin
				res_status_q <= STAT_EXTRACTED;
			end
			DP_REFUSE_FULL: begin
				res_status_q <= STAT_FULL;
				res_entry_q  <= '0;
			end
			DP_REFUSE_EMPTY: begin
				res_status_q <= STAT_EMPTY;
				res_entry_q  <= '0;
			end
			DP_UP_MOVE: begin
				hole_q <= parent;
			end
			DP_EX_LOAD: begin
				res_entry_q <= rd0_q;
				moving_q    <= rd1_q;
				hole_q      <= '0;
			end
			DP_DN_MOVE: begin
				hole_q <= child_idx;
			end
			default: begin
				hole_q <= hole_q;
			end
		endcase
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.status  <= res_status_q;
			out_q.tag_out <= res_entry_q.tag;
			out_q.key_out <= res_entry_q.key;
			out_q.fill    <= FILL_W'(count_q);
		end
	end

	assign out_data = out_q;

endmodule
`default_nettype wire

// ===== sv/binary_min_heap_priority_queue_top.sv =====
// Binary min-heap priority queue, one operation at a time.
// Insert: the new entry climbs from the new last slot toward the root. Extract: the root is read out and
// the last entry sinks from the root toward the leaves. A refused insert or extract skips the sift.
// Each sift level passes through a check and a compare state; the result then waits for a free output register.
// The next operation is taken in the cycle after the result loads.
// Reset: arst_n clears the entry count and control state; heap store is not cleared.
`default_nettype none
module binary_min_heap_priority_queue_top #(
	parameter int CAPACITY = bmhpq_pkg::CAPACITY_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire bmhpq_pkg::in_item_t  in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output bmhpq_pkg::out_item_t      out_data
);
	import bmhpq_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer
	bmhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_kind   (in_data.kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// storage and compare datapath
	bmhpq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

// ===== sv/bmhpq_checker.sv =====
// port level checks of the heap queue and their binding
`default_nettype none
`include "binary_min_heap_priority_queue_top_defines.svh"
module bmhpq_checker #(
	parameter int CAPACITY = bmhpq_pkg::CAPACITY_DEF
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire bmhpq_pkg::in_item_t  in_data,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire bmhpq_pkg::out_item_t out_data
);
	import bmhpq_pkg::*;

	logic in_beat;

	assign in_beat = in_valid && in_ready && (in_data.kind == KIND_INSERT
		|| in_data.kind == KIND_EXTRACT);

	// no result valid right after reset is seen
	`BMHPQ_ASSERT_ALWAYS(a_rst_quiet, !arst_n |=> !out_valid, "output valid during reset")

	// a stalled result beat holds
	`BMHPQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

	// one operation at a time
	`BMHPQ_ASSERT(a_one_item, in_beat |=> !in_ready, "input taken while busy")

	// refused on full reports a full heap and no entry
	`BMHPQ_ASSERT(a_full_fill, out_valid && out_data.status == STAT_FULL |-> out_data.fill == FILL_W'(CAPACITY) && out_data.key_out == '0, "bad full result")

	// refused on empty reports an empty heap and no entry
	`BMHPQ_ASSERT(a_empty_fill, out_valid && out_data.status == STAT_EMPTY |-> out_data.fill == '0 && out_data.tag_out == '0, "bad empty result")

endmodule

bind binary_min_heap_priority_queue_top bmhpq_checker #(
	.CAPACITY (CAPACITY)
) u_bmhpq_checker (.*);
`default_nettype wire
